[hw/rtl/scf_pkg.sv]
package scf_pkg;

   // Widths fixed by the item fields.
   localparam int PLANE_W      = 15;
   localparam int LANE_W       = 16;
   localparam int PLANES       = 4;
   localparam int ROW_COUNT_W  = 3;
   localparam int PAIR_IDX_W   = 4;
   localparam int ROWS_LIMIT   = 6;

   localparam int MAX_ROWS_DEFAULT = 6;
   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 3'd6;

   typedef struct packed {
      logic [PLANE_W-1:0] plane_three;
      logic [PLANE_W-1:0] plane_two;
      logic [PLANE_W-1:0] plane_one;
      logic [PLANE_W-1:0] plane_zero;
   } req_type;

   typedef struct packed {
      logic [PLANE_W-1:0] canon_three;
      logic [PLANE_W-1:0] canon_two;
      logic [PLANE_W-1:0] canon_one;
      logic [PLANE_W-1:0] canon_zero;
   } rsp_type;

   // Four planes, plane 0 in the lowest lane.
   typedef logic [PLANES-1:0][LANE_W-1:0] lanes_type;

   // Control that travels with one permutation through the evaluator.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } eval_ctl_type;

   // Lexicographic index of pair (x, y), x < y, among n rows.
   function automatic logic [PAIR_IDX_W-1:0] pair_slot(
      input logic [ROW_COUNT_W-1:0] x,
      input logic [ROW_COUNT_W-1:0] y,
      input logic [ROW_COUNT_W-1:0] n
   );
      logic [PAIR_IDX_W-1:0] acc;
      acc = '0;
      for (int r = 0; r < ROWS_LIMIT - 1; r++) begin
         if (ROW_COUNT_W'(r) < x) begin
            acc = acc + PAIR_IDX_W'(n) - PAIR_IDX_W'(r) - PAIR_IDX_W'(1);
         end
      end
      acc = acc + PAIR_IDX_W'(y) - PAIR_IDX_W'(x) - PAIR_IDX_W'(1);
      return acc;
   endfunction

   // Number of pairs among n rows.
   function automatic logic [PAIR_IDX_W-1:0] pairs_among(
      input logic [ROW_COUNT_W-1:0] n
   );
      logic [PAIR_IDX_W-1:0] acc;
      acc = '0;
      for (int r = 1; r < ROWS_LIMIT; r++) begin
         if (ROW_COUNT_W'(r) < n) begin
            acc = acc + PAIR_IDX_W'(r);
         end
      end
      return acc;
   endfunction

endpackage

[hw/rtl/scf_perm_eval.sv]
module scf_perm_eval import scf_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   localparam int RowW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  eval_ctl_type           ctl,
   input  logic [RowW-1:0]        perm [MAX_ROWS],
   input  lanes_type              raw,
   input  logic [ROW_COUNT_W-1:0] rows,
   output logic                   done,
   output rsp_type                best
);

   // Stage 1: move every pair bit to the index of its permuted pair.
   lanes_type    img_in,    img_ff;
   eval_ctl_type ctl1_in,   ctl1_ff;
   // Stage 2: five-comparator sorting network.
   lanes_type    sorted_in, sorted_ff;
   eval_ctl_type ctl2_in,   ctl2_ff;
   // Stage 3: keep the smallest packing.
   lanes_type    best_in,   best_ff;
   logic         done_in,   done_ff;
   logic         take_best;

   always_comb begin
      logic [ROW_COUNT_W-1:0] lo, hi;
      logic [PAIR_IDX_W-1:0]  src, dst;
      img_in = '0;
      lo     = '0;
      hi     = '0;
      src    = '0;
      dst    = '0;
      for (int a = 0; a < MAX_ROWS; a++) begin
         for (int b = a + 1; b < MAX_ROWS; b++) begin
            if (ROW_COUNT_W'(b) < rows) begin
               if (perm[a] < perm[b]) begin
                  lo = ROW_COUNT_W'(perm[a]);
                  hi = ROW_COUNT_W'(perm[b]);
               end else begin
                  lo = ROW_COUNT_W'(perm[b]);
                  hi = ROW_COUNT_W'(perm[a]);
               end
               src = pair_slot(ROW_COUNT_W'(a), ROW_COUNT_W'(b), rows);
               dst = pair_slot(lo, hi, rows);
               for (int c = 0; c < PLANES; c++) begin
                  img_in[c][dst] = img_in[c][dst] | raw[c][src];
               end
            end
         end
      end
      ctl1_in = ctl;
   end

   always_comb begin
      lanes_type  q;
      logic [LANE_W-1:0] t;
      q = img_ff;
      t = '0;
      if (q[1] < q[0]) begin t = q[0]; q[0] = q[1]; q[1] = t; end
      if (q[3] < q[2]) begin t = q[2]; q[2] = q[3]; q[3] = t; end
      if (q[2] < q[0]) begin t = q[0]; q[0] = q[2]; q[2] = t; end
      if (q[3] < q[1]) begin t = q[1]; q[1] = q[3]; q[3] = t; end
      if (q[2] < q[1]) begin t = q[1]; q[1] = q[2]; q[2] = t; end
      sorted_in = q;
      ctl2_in   = ctl1_ff;
   end

   // Lane 3 is most significant, so the packed vector compares as the packing.
   assign take_best = ctl2_ff.valid && (ctl2_ff.first || (sorted_ff < best_ff));
   assign best_in   = take_best ? sorted_ff : best_ff;
   assign done_in   = ctl2_ff.valid && ctl2_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl2_in;
         done_ff <= done_in;
      end
      img_ff    <= img_in;
      sorted_ff <= sorted_in;
      best_ff   <= best_in;
   end

   assign done             = done_ff;
   assign best.canon_zero  = best_ff[0][PLANE_W-1:0];
   assign best.canon_one   = best_ff[1][PLANE_W-1:0];
   assign best.canon_two   = best_ff[2][PLANE_W-1:0];
   assign best.canon_three = best_ff[3][PLANE_W-1:0];

endmodule

[hw/rtl/symmetry_canonical_form.sv]
// Canonical form of a four-color pair-plane state under row and color
// permutation.
// A word is taken on the input channel at a rising clock edge where start is
// high and busy is low. Its four planes are bitmasks over the row pairs,
// numbered (0,1),(0,2),...,(1,2),... for the configured row count n. Bits at
// or above n*(n-1)/2 are ignored.
// The block walks all n! row permutations in lexicographic order, one per
// clock cycle, through a three-stage evaluator (pair image, sort, compare)
// and keeps the smallest packing of the sorted planes.
// The result word appears on rsp_data for exactly one cycle with rsp_valid
// high, once the evaluator has compared the last permutation.
// The receiver cannot stall, so it must take the word in that cycle.
// Busy drops in the cycle that shows the result, so the next word can be
// taken from that cycle on; no new word is taken while the walk runs.
// The row count register is written through csr_write_en and csr_write_data.
// Write it only while the block is idle; the block does not enforce this.
// Values below two act as two and values above MAX_ROWS act as MAX_ROWS.
// Reset returns the sequencer to idle, drops any result in flight and sets
// the row count to six.
module symmetry_canonical_form import scf_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   localparam int RowW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [ROW_COUNT_W-1:0] csr_write_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]             state_in, state_ff;
   logic [ROW_COUNT_W-1:0] row_count_in, row_count_ff;
   logic [ROW_COUNT_W-1:0] rows_in, rows_ff;
   logic [RowW-1:0]        perm_in [MAX_ROWS];
   logic [RowW-1:0]        perm_ff [MAX_ROWS];
   lanes_type              raw_in, raw_ff;
   logic                   first_in, first_ff;
   logic                   rsp_valid_in, rsp_valid_ff;
   rsp_type                rsp_data_in, rsp_data_ff;

   logic [ROW_COUNT_W-1:0] rows_eff;
   logic [PAIR_IDX_W-1:0]  pairs_eff;
   lanes_type              req_lanes;
   logic                   has_next;
   logic [RowW-1:0]        pivot, swap_pos;
   logic [RowW-1:0]        perm_swap [MAX_ROWS];
   logic [RowW-1:0]        perm_next [MAX_ROWS];
   eval_ctl_type           eval_ctl;
   logic                   eval_done;
   rsp_type                eval_best;

   // Clamp the register to the supported row range.
   always_comb begin
      if (row_count_ff < ROW_COUNT_W'(2)) begin
         rows_eff = ROW_COUNT_W'(2);
      end else if (row_count_ff > ROW_COUNT_W'(MAX_ROWS)) begin
         rows_eff = ROW_COUNT_W'(MAX_ROWS);
      end else begin
         rows_eff = row_count_ff;
      end
   end

   assign pairs_eff = pairs_among(rows_eff);

   // Drop the pair bits that are not active for this row count.
   always_comb begin
      req_lanes[0] = {1'b0, req_data.plane_zero};
      req_lanes[1] = {1'b0, req_data.plane_one};
      req_lanes[2] = {1'b0, req_data.plane_two};
      req_lanes[3] = {1'b0, req_data.plane_three};
      for (int k = 0; k < LANE_W; k++) begin
         if (PAIR_IDX_W'(k) >= pairs_eff || k >= PLANE_W) begin
            for (int c = 0; c < PLANES; c++) begin
               req_lanes[c][k] = 1'b0;
            end
         end
      end
   end

   // Next permutation in lexicographic order over the first rows_ff rows:
   // find the rightmost ascent, swap its head with the rightmost larger
   // entry, then reverse the tail.
   always_comb begin
      has_next = 1'b0;
      pivot    = '0;
      for (int i = 1; i < MAX_ROWS; i++) begin
         if (ROW_COUNT_W'(i) < rows_ff && perm_ff[i-1] < perm_ff[i]) begin
            has_next = 1'b1;
            pivot    = RowW'(i - 1);
         end
      end
      swap_pos = '0;
      for (int j = 0; j < MAX_ROWS; j++) begin
         if (ROW_COUNT_W'(j) < rows_ff && RowW'(j) > pivot &&
             perm_ff[j] > perm_ff[pivot]) begin
            swap_pos = RowW'(j);
         end
      end
      perm_swap           = perm_ff;
      perm_swap[pivot]    = perm_ff[swap_pos];
      perm_swap[swap_pos] = perm_ff[pivot];
      perm_next           = perm_swap;
      for (int k = 0; k < MAX_ROWS; k++) begin
         if (RowW'(k) > pivot && ROW_COUNT_W'(k) < rows_ff) begin
            perm_next[k] = perm_swap[RowW'(PAIR_IDX_W'(rows_ff) + PAIR_IDX_W'(pivot)
                                            - PAIR_IDX_W'(k))];
         end
      end
   end

   assign eval_ctl.valid = (state_ff == ST_RUN);
   assign eval_ctl.first = first_ff;
   assign eval_ctl.last  = !has_next;

   // Sequencer: load on start, walk the permutations, then wait for the
   // evaluator pipeline to finish the last one.
   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      perm_in      = perm_ff;
      raw_in       = raw_ff;
      first_in     = first_ff;
      row_count_in = csr_write_en ? csr_write_data : row_count_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               rows_in  = rows_eff;
               raw_in   = req_lanes;
               first_in = 1'b1;
               for (int r = 0; r < MAX_ROWS; r++) begin
                  perm_in[r] = RowW'(r);
               end
            end
         end
         ST_RUN: begin
            first_in = 1'b0;
            perm_in  = perm_next;
            if (!has_next) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (eval_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = eval_best;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_count_ff <= ROW_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rows_ff     <= rows_in;
      perm_ff     <= perm_in;
      raw_ff      <= raw_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   scf_perm_eval #(
      .MAX_ROWS (MAX_ROWS)
   ) u_eval (
      .clock (clock),
      .reset (reset),
      .ctl   (eval_ctl),
      .perm  (perm_ff),
      .raw   (raw_ff),
      .rows  (rows_ff),
      .done  (eval_done),
      .best  (eval_best)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A result word is never followed by another in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("two result words in consecutive cycles");

   // An accepted word always makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start the walk");

   // The walk ends by waiting for the evaluator, never by going idle directly.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && !has_next) |=> (state_ff == ST_WAIT))
      else $error("last permutation did not enter the wait state");

   // The evaluator only reports done while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      eval_done |-> (state_ff == ST_WAIT))
      else $error("evaluator finished outside the wait state");
`endif

endmodule
